// ----- rtl/gmne_pkg.sv -----
// Shared types and constants for the grid map neighbor engine.
package gmne_pkg;

  // Default sizing
  localparam int NODE_DEPTH_DEF = 1024;
  localparam int COORD_MAX_DEF  = 255;

  // Result limits
  localparam int MAX_RES  = 4;
  localparam int DIST_SAT = 511;

  // Map characters
  localparam logic [7:0] CHAR_WALL  = 8'h23;  // '#'
  localparam logic [7:0] CHAR_NL    = 8'h0A;  // newline
  localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_GOAL  = 8'h47;  // 'G'

  // Transaction actions
  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_NEIGHBOR = 2'd1,
    ACT_DIST     = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_BAD_ID  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NB_REF,
    ST_SCAN,
    ST_NB_LAST,
    ST_DIST_A,
    ST_DIST_B
  } state_t;

endpackage

// ----- rtl/gmne_cell_store.sv -----
// Node coordinate table: one write port, one registered read port.
module gmne_cell_store #(
  parameter int DEPTH = gmne_pkg::NODE_DEPTH_DEF,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  import gmne_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/grid_map_neighbor_engine.sv -----
// Grid map neighbor engine: map loader, neighbor scan and distance queries.
// Load and clear: busy stays low, no result.
// Unknown-id query: busy stays low, one result in the cycle after accept.
// Distance query: busy in ST_DIST_A and ST_DIST_B, result registered from ST_DIST_B.
// Neighbor query: busy in ST_NB_REF, ST_SCAN (one table read per node) and ST_NB_LAST, last result after.
// One transaction in flight; receiver cannot stall.
// Reset clears counters, ids and overflow; the coordinate table is not cleared.
module grid_map_neighbor_engine #(
  parameter int NODE_DEPTH = gmne_pkg::NODE_DEPTH_DEF,
  parameter int COORD_MAX  = gmne_pkg::COORD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_char_code,
  input  logic [9:0] in_node_a,
  input  logic [9:0] in_node_b,
  output logic       out_strobe,
  output logic [9:0] out_neighbor_node,
  output logic [8:0] out_distance,
  output logic [1:0] out_status,
  output logic       out_last,
  output logic [9:0] out_start_node,
  output logic [9:0] out_goal_node,
  output logic [10:0] out_node_count,
  output logic       out_overflow
);
  import gmne_pkg::*;

  localparam int CW   = $clog2(COORD_MAX + 1);
  localparam int IW   = $clog2(NODE_DEPTH);
  localparam int CNTW = $clog2(NODE_DEPTH + 1);
  localparam int QW   = (CNTW > 10) ? CNTW : 10;
  localparam int SUMW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int FCW  = $clog2(MAX_RES + 1);

  // State
  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   row_r, row_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  logic [IW-1:0]   goal_r, goal_nxt;
  logic            drop_r, drop_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [FCW-1:0]  found_r, found_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [IW-1:0]   pend_id_r, pend_id_nxt;
  logic [2*CW-1:0] ref_r, ref_nxt;
  logic [9:0]      b_r, b_nxt;

  // Result registers
  logic            strb_r, strb_nxt;
  logic [9:0]      onb_r, onb_nxt;
  logic [8:0]      odist_r, odist_nxt;
  logic [1:0]      ostat_r, ostat_nxt;
  logic            olast_r, olast_nxt;

  // Table port signals
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [2*CW-1:0] wr_data;
  logic [IW-1:0]   rd_addr;
  logic [2*CW-1:0] rd_data;

  logic            accept;
  logic            a_bad, b_bad;
  logic [CW-1:0]   dcol, drow;
  logic [SUMW-1:0] dsum;
  logic [8:0]      dist_sat;
  logic            hit;
  logic [CNTW-1:0] idx_inc;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v >= CW'(COORD_MAX)) ? CW'(COORD_MAX) : v + CW'(1);
  endfunction

  gmne_cell_store #(
    .DEPTH (NODE_DEPTH),
    .WIDTH (2 * CW),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign a_bad   = QW'(in_node_a) >= QW'(count_r);
  assign b_bad   = QW'(in_node_b) >= QW'(count_r);
  assign idx_inc = idx_r + CNTW'(1);

  // Manhattan distance between the held reference and the read entry
  always_comb begin
    dcol = (ref_r[2*CW-1:CW] > rd_data[2*CW-1:CW]) ?
           ref_r[2*CW-1:CW] - rd_data[2*CW-1:CW] : rd_data[2*CW-1:CW] - ref_r[2*CW-1:CW];
    drow = (ref_r[CW-1:0] > rd_data[CW-1:0]) ?
           ref_r[CW-1:0] - rd_data[CW-1:0] : rd_data[CW-1:0] - ref_r[CW-1:0];
    dsum = SUMW'(dcol) + SUMW'(drow);
    dist_sat = (dsum > SUMW'(DIST_SAT)) ? 9'(DIST_SAT) : dsum[8:0];
    hit = (dsum == SUMW'(1));
  end

  // Sequencer: next state, table access and results
  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    count_nxt   = count_r;
    start_nxt   = start_r;
    goal_nxt    = goal_r;
    drop_nxt    = drop_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    ref_nxt     = ref_r;
    b_nxt       = b_r;
    strb_nxt    = 1'b0;
    onb_nxt     = onb_r;
    odist_nxt   = odist_r;
    ostat_nxt   = ostat_r;
    olast_nxt   = olast_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[IW-1:0];
    wr_data     = {col_r, row_r};
    rd_addr     = IW'(in_node_a);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_action))
            ACT_LOAD: begin
              if (in_char_code == CHAR_WALL) begin
                col_nxt = sat_inc(col_r);
              end else if (in_char_code == CHAR_NL) begin
                col_nxt = '0;
                row_nxt = sat_inc(row_r);
              end else begin
                if (count_r < CNTW'(NODE_DEPTH)) begin
                  wr_en     = 1'b1;
                  count_nxt = count_r + CNTW'(1);
                  if (in_char_code == CHAR_START) start_nxt = count_r[IW-1:0];
                  if (in_char_code == CHAR_GOAL)  goal_nxt  = count_r[IW-1:0];
                end else begin
                  drop_nxt = 1'b1;
                end
                col_nxt = sat_inc(col_r);
              end
            end
            ACT_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              count_nxt = '0;
              start_nxt = '0;
              goal_nxt  = '0;
              drop_nxt  = 1'b0;
            end
            ACT_NEIGHBOR: begin
              if (a_bad) begin
                strb_nxt  = 1'b1;
                onb_nxt   = '0;
                odist_nxt = '0;
                ostat_nxt = STAT_BAD_ID;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = ST_NB_REF;
              end
            end
            ACT_DIST: begin
              b_nxt = in_node_b;
              if (a_bad || b_bad) begin
                strb_nxt  = 1'b1;
                onb_nxt   = '0;
                odist_nxt = '0;
                ostat_nxt = STAT_BAD_ID;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = ST_DIST_A;
              end
            end
          endcase
        end
      end
      // Latch the queried node, start the scan at id 0
      ST_NB_REF: begin
        ref_nxt    = rd_data;
        rd_addr    = '0;
        idx_nxt    = '0;
        found_nxt  = '0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      // One entry per cycle; a hit releases the previous hit as a non-last result
      ST_SCAN: begin
        rd_addr = idx_inc[IW-1:0];
        idx_nxt = idx_inc;
        if (hit) begin
          if (pend_v_r) begin
            strb_nxt  = 1'b1;
            onb_nxt   = 10'(pend_id_r);
            odist_nxt = 9'd1;
            ostat_nxt = STAT_OK;
            olast_nxt = 1'b0;
          end
          pend_id_nxt = idx_r[IW-1:0];
          pend_v_nxt  = 1'b1;
          found_nxt   = found_r + FCW'(1);
        end
        if ((hit && found_r == FCW'(MAX_RES - 1)) || idx_inc == count_r) begin
          state_nxt = ST_NB_LAST;
        end
      end
      // Final result of a neighbor query
      ST_NB_LAST: begin
        strb_nxt  = 1'b1;
        olast_nxt = 1'b1;
        if (pend_v_r) begin
          onb_nxt   = 10'(pend_id_r);
          odist_nxt = 9'd1;
          ostat_nxt = STAT_OK;
        end else begin
          onb_nxt   = '0;
          odist_nxt = '0;
          ostat_nxt = STAT_NONE;
        end
        state_nxt = ST_IDLE;
      end
      ST_DIST_A: begin
        ref_nxt   = rd_data;
        rd_addr   = IW'(b_r);
        state_nxt = ST_DIST_B;
      end
      ST_DIST_B: begin
        strb_nxt  = 1'b1;
        onb_nxt   = '0;
        odist_nxt = dist_sat;
        ostat_nxt = STAT_OK;
        olast_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      count_r  <= '0;
      start_r  <= '0;
      goal_r   <= '0;
      drop_r   <= 1'b0;
      strb_r   <= 1'b0;
      found_r  <= '0;
      pend_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      count_r  <= count_nxt;
      start_r  <= start_nxt;
      goal_r   <= goal_nxt;
      drop_r   <= drop_nxt;
      strb_r   <= strb_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    ref_r     <= ref_nxt;
    b_r       <= b_nxt;
    onb_r     <= onb_nxt;
    odist_r   <= odist_nxt;
    ostat_r   <= ostat_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_strobe        = strb_r;
  assign out_neighbor_node = onb_r;
  assign out_distance      = odist_r;
  assign out_status        = ostat_r;
  assign out_last          = olast_r;
  assign out_start_node    = 10'(start_r);
  assign out_goal_node     = 10'(goal_r);
  assign out_node_count    = 11'(count_r);
  assign out_overflow      = drop_r;

`ifndef NO_ASSERTIONS
  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= FCW'(MAX_RES))
    else $error("neighbor hit count above limit");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r < count_r)
    else $error("scan index past stored nodes");

  a_nb_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NB_LAST |=> out_strobe && out_last)
    else $error("neighbor query ended without a last result");

  a_ok_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == STAT_OK && !out_last |-> out_distance == 9'd1)
    else $error("non-final neighbor result without unit distance");

  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(count_r) && $stable(drop_r))
    else $error("table state changed during a query");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for grid_map_neighbor_engine: map loads and queries vs. a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gmne_pkg::*;

  localparam int DEPTH        = NODE_DEPTH_DEF;
  localparam int CMAX         = COORD_MAX_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = DEPTH + 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int PRINT_CAP    = 40;
  localparam logic [7:0] CELL_DOT = 8'h2E;  // '.'

  typedef struct packed {
    action_t    act;
    logic [7:0] ch;
    logic [9:0] a;
    logic [9:0] b;
  } grid_cmd_t;

  typedef struct packed {
    logic [9:0]  nb;
    logic [8:0]  gap;
    status_t     status;
    logic        last;
    logic [9:0]  s_node;
    logic [9:0]  g_node;
    logic [10:0] count;
    logic        ovf;
  } grid_answer_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_char_code = '0;
  logic [9:0]  in_node_a = '0;
  logic [9:0]  in_node_b = '0;
  logic        out_strobe;
  logic [9:0]  out_neighbor_node;
  logic [8:0]  out_distance;
  logic [1:0]  out_status;
  logic        out_last;
  logic [9:0]  out_start_node;
  logic [9:0]  out_goal_node;
  logic [10:0] out_node_count;
  logic        out_overflow;

  grid_map_neighbor_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_char_code      (in_char_code),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .out_strobe        (out_strobe),
    .out_neighbor_node (out_neighbor_node),
    .out_distance      (out_distance),
    .out_status        (out_status),
    .out_last          (out_last),
    .out_start_node    (out_start_node),
    .out_goal_node     (out_goal_node),
    .out_node_count    (out_node_count),
    .out_overflow      (out_overflow)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Test bookkeeping
  grid_cmd_t    engine_cmds [$];
  grid_answer_t grid_answers [$];
  int           mismatch_count = 0;
  int           cmds_taken = 0;
  int           cycle_count = 0;
  int           gen_nodes = 0;
  int           idle_left = 0;
  int           burst_left = 0;
  logic         taken = 1'b0;

  // Predicted engine state
  logic [7:0]  map_col [DEPTH];
  logic [7:0]  map_row [DEPTH];
  int unsigned map_nodes = 0;
  logic [7:0]  col_pos = '0;
  logic [7:0]  row_pos = '0;
  logic [9:0]  start_id_q = '0;
  logic [9:0]  goal_id_q = '0;
  logic        overflow_q = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [7:0] sat_step(logic [7:0] v);
    return (v >= CMAX) ? v : v + 8'd1;
  endfunction

  // Manhattan distance between two stored cells
  function automatic int cell_gap(int i, int j);
    int dc;
    int dr;
    dc = int'(map_col[i]) - int'(map_col[j]);
    dr = int'(map_row[i]) - int'(map_row[j]);
    return ((dc < 0) ? -dc : dc) + ((dr < 0) ? -dr : dr);
  endfunction

  function automatic grid_answer_t make_answer(logic [9:0] nb, int d, status_t st, logic last);
    grid_answer_t r;
    r.nb     = nb;
    r.gap    = 9'((d > DIST_SAT) ? DIST_SAT : d);
    r.status = st;
    r.last   = last;
    r.s_node = start_id_q;
    r.g_node = goal_id_q;
    r.count  = 11'(map_nodes);
    r.ovf    = overflow_q;
    return r;
  endfunction

  // Append one expected answer
  task automatic queue_answer(grid_answer_t ans);
    grid_answers = {grid_answers, ans};
  endtask

  // Update the predicted map and queue the answers one command causes
  task automatic apply_grid_cmd(grid_cmd_t c);
    int hits [MAX_RES];
    int n;
    int k;
    n = 0;
    case (c.act)
      ACT_LOAD: begin
        if (c.ch == CHAR_WALL) begin
          col_pos = sat_step(col_pos);
        end else if (c.ch == CHAR_NL) begin
          col_pos = '0;
          row_pos = sat_step(row_pos);
        end else begin
          if (map_nodes < DEPTH) begin
            map_col[map_nodes] = col_pos;
            map_row[map_nodes] = row_pos;
            if (c.ch == CHAR_START) start_id_q = 10'(map_nodes);
            if (c.ch == CHAR_GOAL) goal_id_q = 10'(map_nodes);
            map_nodes++;
          end else begin
            overflow_q = 1'b1;
          end
          col_pos = sat_step(col_pos);
        end
      end
      ACT_CLEAR: begin
        map_nodes  = 0;
        col_pos    = '0;
        row_pos    = '0;
        start_id_q = '0;
        goal_id_q  = '0;
        overflow_q = 1'b0;
      end
      ACT_NEIGHBOR: begin
        if (c.a >= map_nodes) begin
          queue_answer(make_answer('0, 0, STAT_BAD_ID, 1'b1));
        end else begin
          for (k = 0; k < map_nodes && n < MAX_RES; k++) begin
            if (cell_gap(int'(c.a), k) == 1) begin
              hits[n] = k;
              n++;
            end
          end
          if (n == 0)
            queue_answer(make_answer('0, 0, STAT_NONE, 1'b1));
          for (k = 0; k < n; k++)
            queue_answer(make_answer(10'(hits[k]), 1, STAT_OK, k == n - 1));
        end
      end
      ACT_DIST: begin
        if (c.a >= map_nodes || c.b >= map_nodes)
          queue_answer(make_answer('0, 0, STAT_BAD_ID, 1'b1));
        else
          queue_answer(make_answer('0, cell_gap(int'(c.a), int'(c.b)), STAT_OK, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Stimulus helpers; gen_nodes tracks the table size the queue will build
  task automatic add_cmd(action_t act, logic [7:0] ch, logic [9:0] a, logic [9:0] b);
    grid_cmd_t c;
    c = '{act, ch, a, b};
    engine_cmds = {engine_cmds, c};
    if (act == ACT_CLEAR)
      gen_nodes = 0;
    else if (act == ACT_LOAD && ch != CHAR_WALL && ch != CHAR_NL && gen_nodes < DEPTH)
      gen_nodes++;
  endtask

  function automatic logic [9:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (gen_nodes > 0 && roll < 85)
      return 10'($urandom_range(0, gen_nodes - 1));
    if (roll < 92 && gen_nodes < DEPTH)
      return 10'(gen_nodes);
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [7:0] pick_cell_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return CELL_DOT;
    if (roll < 70) return CHAR_WALL;
    if (roll < 75) return CHAR_START;
    if (roll < 80) return CHAR_GOAL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: present the next transaction at the falling edge
  always @(negedge clk) begin : drive_cmds
    grid_cmd_t nxt;
    int roll;
    if (rst_n && !(start && !taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (engine_cmds.size() > 0) begin
        nxt = engine_cmds.pop_front();
        in_action    <= nxt.act;
        in_char_code <= nxt.ch;
        in_node_a    <= nxt.a;
        in_node_b    <= nxt.b;
        start        <= 1'b1;
        // gap before the following transaction: mostly none, some short, a few long
        if (burst_left > 0) begin
          burst_left--;
          idle_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            burst_left = $urandom_range(20, 60);
            idle_left = 0;
          end else if (roll < 60) begin
            idle_left = 0;
          end else if (roll < 90) begin
            idle_left = $urandom_range(1, 3);
          end else begin
            idle_left = $urandom_range(5, 30);
          end
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance: predict at the edge that takes the transaction
  always @(posedge clk) begin : take_cmds
    grid_cmd_t cur;
    taken = rst_n && start && (busy === 1'b0);
    if (taken) begin
      cur.act = action_t'(in_action);
      cur.ch  = in_char_code;
      cur.a   = in_node_a;
      cur.b   = in_node_b;
      apply_grid_cmd(cur);
      cmds_taken++;
    end
  end

  // Monitor: compare each result with the oldest expected answer
  always @(posedge clk) begin : watch_results
    grid_answer_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (grid_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result: node %0d status %0d",
                                  out_neighbor_node, out_status));
      end else begin
        want = grid_answers.pop_front();
        check_field("neighbor_node", 11'(out_neighbor_node), 11'(want.nb));
        check_field("distance", 11'(out_distance), 11'(want.gap));
        check_field("status", 11'(out_status), 11'(want.status));
        check_field("last", 11'(out_last), 11'(want.last));
        check_field("start_node", 11'(out_start_node), 11'(want.s_node));
        check_field("goal_node", 11'(out_goal_node), 11'(want.g_node));
        check_field("node_count", out_node_count, want.count);
        check_field("overflow", 11'(out_overflow), 11'(want.ovf));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int total_cmds;
    int rand_cmds;
    int rows;
    int cols;
    int nq;
    int r;
    int k;
    int roll;

    // Directed: empty-table queries, small map, unknown ids, clear
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd0, 10'd0);
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CHAR_START, 10'd0, 10'd0);      // id0 (0,0)
    add_cmd(ACT_LOAD, CELL_DOT, 10'd0, 10'd0);        // id1 (1,0)
    add_cmd(ACT_LOAD, CHAR_WALL, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, 8'h00, 10'd0, 10'd0);           // id2 (3,0)
    add_cmd(ACT_LOAD, CHAR_NL, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, 8'hFF, 10'd0, 10'd0);           // id3 (0,1)
    add_cmd(ACT_LOAD, CHAR_GOAL, 10'd0, 10'd0);       // id4 (1,1)
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd1, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd2, 10'd0);       // isolated cell
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd4, 10'd1023);
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd4);
    add_cmd(ACT_DIST, 8'h00, 10'd2, 10'd3);
    add_cmd(ACT_DIST, 8'h00, 10'd1023, 10'd0);
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd1023);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd1023, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd5, 10'd0);       // id equal to count
    add_cmd(ACT_CLEAR, 8'h00, 10'd0, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CHAR_GOAL, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CHAR_START, 10'd0, 10'd0);
    add_cmd(ACT_DIST, 8'h00, 10'd1, 10'd0);

    // Saturated coordinates: cells piling up at the last column and row
    add_cmd(ACT_CLEAR, 8'h00, 10'd0, 10'd0);
    for (k = 0; k < CMAX - 1; k++) add_cmd(ACT_LOAD, CHAR_WALL, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CELL_DOT, 10'd0, 10'd0);        // id0 at column CMAX-1
    for (k = 0; k < 5; k++)
      add_cmd(ACT_LOAD, (k == 2) ? CHAR_START : CELL_DOT, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CHAR_WALL, 10'd0, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd0, 10'd0);       // more than four neighbors
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd1, 10'd0);
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd5);
    for (k = 0; k < CMAX + 45; k++) add_cmd(ACT_LOAD, CHAR_NL, 10'd0, 10'd0);
    add_cmd(ACT_LOAD, CELL_DOT, 10'd0, 10'd0);        // id6 (0,CMAX)
    add_cmd(ACT_LOAD, CHAR_GOAL, 10'd0, 10'd0);       // id7 (1,CMAX)
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd6);
    add_cmd(ACT_DIST, 8'h00, 10'd5, 10'd6);           // largest distance
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd6, 10'd0);

    // Full table: loads past the end are dropped, start and goal not recorded
    add_cmd(ACT_CLEAR, 8'h00, 10'd0, 10'd0);
    for (k = 0; k < DEPTH + 6; k++) begin
      if (k > 0 && k % 40 == 0) add_cmd(ACT_LOAD, CHAR_NL, 10'd0, 10'd0);
      if (k % 13 == 5) add_cmd(ACT_LOAD, CHAR_WALL, 10'd0, 10'd0);
      if (k == 100 || k == DEPTH + 2)
        add_cmd(ACT_LOAD, CHAR_START, 10'd0, 10'd0);
      else if (k == 900 || k == DEPTH + 4)
        add_cmd(ACT_LOAD, CHAR_GOAL, 10'd0, 10'd0);
      else
        add_cmd(ACT_LOAD, CELL_DOT, 10'd0, 10'd0);
    end
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd1023, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd0, 10'd0);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd500, 10'd0);
    add_cmd(ACT_DIST, 8'h00, 10'd0, 10'd1023);
    add_cmd(ACT_DIST, 8'h00, 10'd1023, 10'd1);
    add_cmd(ACT_NEIGHBOR, 8'h00, 10'd1022, 10'd0);

    // Random: small maps with random content, then queries, some noise
    rand_cmds = 0;
    while (rand_cmds < RANDOM_ITEMS) begin
      if (gen_nodes > 150 || $urandom_range(0, 3) == 0) begin
        add_cmd(ACT_CLEAR, 8'($urandom_range(0, 255)), pick_id(), pick_id());
        rand_cmds++;
      end
      rows = $urandom_range(1, 5);
      cols = $urandom_range(1, 8);
      for (r = 0; r < rows; r++) begin
        for (k = 0; k < cols; k++) begin
          add_cmd(ACT_LOAD, pick_cell_char(), pick_id(), pick_id());
          rand_cmds++;
        end
        add_cmd(ACT_LOAD, CHAR_NL, pick_id(), pick_id());
        rand_cmds++;
      end
      nq = $urandom_range(3, 10);
      for (k = 0; k < nq; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          add_cmd(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        else if (roll < 60)
          add_cmd(ACT_NEIGHBOR, 8'($urandom_range(0, 255)), pick_id(), pick_id());
        else
          add_cmd(ACT_DIST, 8'($urandom_range(0, 255)), pick_id(), pick_id());
        rand_cmds++;
      end
    end
    total_cmds = engine_cmds.size();

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmds_taken < total_cmds) @(posedge clk);
    while (grid_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && grid_answers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
